### rtl/ptst_pkg.sv
package ptst_pkg;

	localparam int CmdW      = 2;
	localparam int IntervalW = 32;
	localparam int SlotW     = 4;
	localparam int StatusW   = 2;
	localparam int MaskW     = 16;
	localparam int CountW    = 32;
	localparam int RateW     = 21;
	localparam int MsPerSec  = 1000;
	localparam int MsW       = 10;
	localparam int NumW      = CountW + MsW;
	localparam int InDataW   = 40;
	localparam int OutDataW  = 120;
	localparam logic [RateW-1:0] RateReset = RateW'(100);

	localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
	localparam logic [CmdW-1:0] CMD_REG   = 2'd1;
	localparam logic [CmdW-1:0] CMD_UNREG = 2'd2;
	localparam logic [CmdW-1:0] CMD_QUERY = 2'd3;

	localparam logic [StatusW-1:0] ST_OK   = 2'd0;
	localparam logic [StatusW-1:0] ST_FULL = 2'd1;
	localparam logic [StatusW-1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic load;
		logic tick_inc;
		logic walk_step;
		logic apply;
		logic div_start;
		logic div_step;
		logic out_load;
	} ptst_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic walk_last;
		logic div_last;
		logic out_busy;
	} ptst_stat_t;

endpackage

### rtl/ptst_ctrl.sv
module ptst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ptst_pkg::ptst_stat_t stat,
	output ptst_pkg::ptst_cmd_t  cmd
);
	import ptst_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK, S_MUL, S_DIV, S_FIN} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_EXEC: begin
				cmd.tick_inc = stat.is_tick;
				cmd.apply    = !stat.is_tick;
			end
			S_WALK: cmd.walk_step = 1'b1;
			S_MUL:  cmd.div_start = 1'b1;
			S_DIV:  cmd.div_step  = 1'b1;
			S_FIN:  cmd.out_load  = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= stat.is_tick ? S_WALK : S_MUL;
				S_WALK: if (stat.walk_last) state_q <= S_MUL;
				S_MUL:  state_q <= S_DIV;
				S_DIV:  if (stat.div_last) state_q <= S_FIN;
				S_FIN:  if (!stat.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/ptst_dp.sv
module ptst_dp #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ptst_pkg::ptst_cmd_t             cmd,
	output ptst_pkg::ptst_stat_t            stat,
	input  logic [ptst_pkg::CmdW-1:0]       in_cmd,
	input  logic [ptst_pkg::IntervalW-1:0]  in_interval,
	input  logic [ptst_pkg::SlotW-1:0]      in_slot,
	input  logic                            cfg_we,
	input  logic [ptst_pkg::RateW-1:0]      cfg_rate,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ptst_pkg::StatusW-1:0]    out_status,
	output logic [ptst_pkg::SlotW-1:0]      out_slot,
	output logic [ptst_pkg::MaskW-1:0]      out_mask,
	output logic [ptst_pkg::CountW-1:0]     out_ticks,
	output logic [ptst_pkg::CountW-1:0]     out_sec,
	output logic [ptst_pkg::CountW-1:0]     out_ms
);
	import ptst_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int DW = $clog2(NumW);

	logic [CmdW-1:0]      cmd_q;
	logic [IntervalW-1:0] interval_q;
	logic [SlotW-1:0]     slot_q;
	logic [RateW-1:0]     rate_q;
	logic [CountW-1:0]    ticks_q;
	logic [SLOT_COUNT-1:0] active_q;
	logic [IntervalW-1:0] ival_q [SLOT_COUNT];
	logic [IntervalW-1:0] cdown_q [SLOT_COUNT];
	logic [IW-1:0]        idx_q;
	logic [MaskW-1:0]     mask_q;
	logic [StatusW-1:0]   status_q;
	logic [SlotW-1:0]     grant_q;
	logic [DW-1:0]        dcnt_q;
	logic [NumW-1:0]      nsec_q, nms_q;
	logic [RateW-1:0]     rsec_q, rms_q;
	logic                 ovalid_q;

	// Lowest free slot.
	logic          free_any;
	logic [IW-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// One restoring division step for each quotient.
	logic [RateW:0] sh_sec, sh_ms;
	logic           ge_sec, ge_ms;
	assign sh_sec = {rsec_q, nsec_q[NumW-1]};
	assign sh_ms  = {rms_q, nms_q[NumW-1]};
	assign ge_sec = sh_sec >= {1'b0, rate_q};
	assign ge_ms  = sh_ms >= {1'b0, rate_q};

	logic [RateW:0] sub_sec, sub_ms;
	assign sub_sec = sh_sec - {1'b0, rate_q};
	assign sub_ms  = sh_ms - {1'b0, rate_q};

	assign stat.is_tick   = (cmd_q == CMD_TICK);
	assign stat.walk_last = (idx_q == IW'(SLOT_COUNT - 1));
	assign stat.div_last  = (dcnt_q == DW'(NumW - 1));
	assign stat.out_busy  = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= RateReset;
			ticks_q  <= '0;
			active_q <= '0;
			ovalid_q <= 1'b0;
			cmd_q    <= CMD_QUERY;
			idx_q    <= '0;
			dcnt_q   <= '0;
		end else begin
			if (cfg_we) rate_q <= cfg_rate;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (cmd.load) begin
				cmd_q      <= in_cmd;
				interval_q <= in_interval;
				slot_q     <= in_slot;
				status_q   <= ST_OK;
				grant_q    <= '0;
				mask_q     <= '0;
				idx_q      <= '0;
			end
			if (cmd.tick_inc) ticks_q <= ticks_q + 1'b1;
			if (cmd.walk_step) begin
				idx_q <= idx_q + 1'b1;
				if (active_q[idx_q]) begin
					if (cdown_q[idx_q] != '0) begin
						cdown_q[idx_q] <= cdown_q[idx_q] - 1'b1;
					end else begin
						mask_q[idx_q] <= 1'b1;
						cdown_q[idx_q] <= ival_q[idx_q];
					end
				end
			end
			if (cmd.apply) begin
				if (cmd_q == CMD_REG) begin
					if (interval_q == '0) begin
						status_q <= ST_ZERO;
					end else if (!free_any) begin
						status_q <= ST_FULL;
					end else begin
						active_q[free_idx] <= 1'b1;
						ival_q[free_idx]   <= interval_q;
						cdown_q[free_idx]  <= interval_q;
						grant_q            <= SlotW'(free_idx);
					end
				end else if (cmd_q == CMD_UNREG) begin
					if (32'(slot_q) < SLOT_COUNT) active_q[slot_q[IW-1:0]] <= 1'b0;
				end
			end
			if (cmd.div_start) begin
				dcnt_q <= '0;
				nsec_q <= NumW'(ticks_q);
				nms_q  <= NumW'(ticks_q) * NumW'(MsPerSec);
				rsec_q <= '0;
				rms_q  <= '0;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
				nsec_q <= {nsec_q[NumW-2:0], ge_sec};
				nms_q  <= {nms_q[NumW-2:0], ge_ms};
				rsec_q <= ge_sec ? sub_sec[RateW-1:0] : sh_sec[RateW-1:0];
				rms_q  <= ge_ms ? sub_ms[RateW-1:0] : sh_ms[RateW-1:0];
			end
			if (cmd.out_load) ovalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= status_q;
			out_slot   <= grant_q;
			out_mask   <= mask_q;
			out_ticks  <= ticks_q;
			out_sec    <= (nsec_q[NumW-1:CountW] != '0) ? '1 : nsec_q[CountW-1:0];
			out_ms     <= (nms_q[NumW-1:CountW] != '0) ? '1 : nms_q[CountW-1:0];
		end
	end

	assign out_valid = ovalid_q;

endmodule

### rtl/periodic_timer_slot_table.sv
// Periodic timer slot table.
// Requests enter on the s_axis channel: cmd selects tick, register, unregister
// or query, with the interval and slot fields alongside. Every request gives
// exactly one result on the m_axis channel: status, granted slot, fire mask,
// tick count, and uptime in seconds and milliseconds at the configured rate.
// The tick rate is written on the cfg channel, which is always ready.
// A tick walks the slot table one slot per cycle; every request then runs a
// restoring divider that settles one quotient bit per cycle over 42 bits.
// One request is in work at a time.
// A new request is accepted while the previous result still waits; if the
// receiver stalls, the new one halts before its result register until the
// old result is taken.
// Reset clears the counter and all slots and sets the rate to 100 Hz.
module periodic_timer_slot_table #(
	parameter int SLOT_COUNT = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,  // cmd[1:0], interval[33:2], slot[37:34]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], slot_out[5:2], fire_mask[21:6], tick_total[53:22],
	// uptime_seconds[85:54], uptime_ms[117:86]
	output logic [119:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [20:0]  cfg_data       // tick_rate_hz
);
	import ptst_pkg::*;

	ptst_cmd_t  cmd;
	ptst_stat_t stat;

	logic [StatusW-1:0] o_status;
	logic [SlotW-1:0]   o_slot;
	logic [MaskW-1:0]   o_mask;
	logic [CountW-1:0]  o_ticks, o_sec, o_ms;

	assign cfg_ready = 1'b1;

	ptst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptst_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_cmd      (s_axis_tdata[1:0]),
		.in_interval (s_axis_tdata[33:2]),
		.in_slot     (s_axis_tdata[37:34]),
		.cfg_we      (cfg_valid),
		.cfg_rate    (cfg_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (o_status),
		.out_slot    (o_slot),
		.out_mask    (o_mask),
		.out_ticks   (o_ticks),
		.out_sec     (o_sec),
		.out_ms      (o_ms)
	);

	assign m_axis_tdata = {2'b00, o_ms, o_sec, o_ticks, o_mask, o_slot, o_status};

endmodule
